@@ hdl/dmoms_pkg.sv @@
// Shared types, constants and helpers for the one-mismatch DNA motif scanner.
package dmoms_pkg;

  // Default sizing of the scanner
  localparam int MaxMotifBasesDef = 32;
  localparam int PositionBitsDef  = 16;

  // Fixed field widths
  localparam int MotifW   = 64;
  localparam int LenW     = 6;
  localparam int HitsW    = 8;
  localparam int CharW    = 8;
  localparam int CfgIdxW  = 2;
  localparam int CodeW    = 3;

  typedef logic [LenW-1:0]  len_t;
  typedef logic [HitsW-1:0] hits_t;
  typedef logic [CodeW-1:0] code_t;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MOTIF_CODE   = 2'd0,
    CFG_MOTIF_LENGTH = 2'd1,
    CFG_MAX_HITS     = 2'd2
  } cfg_reg_e;

  // Register reset values
  localparam logic [MotifW-1:0] MotifCodeRst   = '0;
  localparam len_t              MotifLengthRst = len_t'(22);
  localparam hits_t             MaxHitsRst     = hits_t'(3);

  // Base codes; anything that is not a base gets CodeNone
  localparam code_t CodeA    = code_t'(0);
  localparam code_t CodeC    = code_t'(1);
  localparam code_t CodeG    = code_t'(2);
  localparam code_t CodeT    = code_t'(3);
  localparam code_t CodeNone = code_t'(4);

  // ASCII to base code, either case
  function automatic code_t base_code(input logic [CharW-1:0] ch);
    code_t code;
    case (ch)
      8'h41, 8'h61: code = CodeA;
      8'h43, 8'h63: code = CodeC;
      8'h47, 8'h67: code = CodeG;
      8'h54, 8'h74: code = CodeT;
      default:      code = CodeNone;
    endcase
    return code;
  endfunction

endpackage

@@ hdl/dna_motif_one_mismatch_scan.sv @@
// Top level of the one-mismatch DNA motif scanner.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------------
//  in      | in        | in_valid_i / in_stall_o  | base_char_i, read_start_i
//  out     | out       | out_valid_o / out_stall_i| hit_found_o, hit_position_o,
//          |           |                        | hit_exact_o, hits_so_far_o
//  cfg     | in        | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// One character per cycle while the input is not stalled; each transfer in gives one result in the next cycle.
// The window compare and hit check sit between the scan state and the result register.
// Reset clears the scan state and the result register, and loads register defaults.
// The input stalls only while a held result is stalled at the output.
// Configuration writes are always ready.
module dna_motif_one_mismatch_scan #(
  parameter int MaxMotifBases = dmoms_pkg::MaxMotifBasesDef,
  parameter int PositionBits  = dmoms_pkg::PositionBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // character input
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [dmoms_pkg::CharW-1:0]       base_char_i,
  input  logic                              read_start_i,
  // result output
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              hit_found_o,
  output logic [PositionBits-1:0]           hit_position_o,
  output logic                              hit_exact_o,
  output logic [dmoms_pkg::HitsW-1:0]       hits_so_far_o,
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [dmoms_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [dmoms_pkg::MotifW-1:0]      cfg_data_i
);

  localparam int WinW = 2 * MaxMotifBases;
  localparam int RunW = $clog2(MaxMotifBases + 1);
  localparam logic [PositionBits-1:0] PosMax = '1;
  localparam dmoms_pkg::len_t LenMax = dmoms_pkg::len_t'(MaxMotifBases);
  localparam logic [RunW-1:0] RunMax = RunW'(MaxMotifBases);

  // configuration registers
  logic [dmoms_pkg::MotifW-1:0] motif_q;
  dmoms_pkg::len_t              motif_len_q;
  dmoms_pkg::hits_t             max_hits_q;

  // scan state
  logic [WinW-1:0]         win_q, win_d;
  logic [RunW-1:0]         run_q, run_d;
  logic [PositionBits-1:0] pos_q, pos_d;
  dmoms_pkg::hits_t        tally_q, tally_d;

  // result register
  logic                    out_valid_q, out_valid_d;
  logic                    found_q, found_d;
  logic [PositionBits-1:0] start_q, start_d;
  logic                    exact_q, exact_d;
  dmoms_pkg::hits_t        hits_q;

  logic                    in_xfer;
  dmoms_pkg::code_t        code;
  dmoms_pkg::len_t         len_eff;
  logic [WinW-1:0]         win_cur, win_shift, diff;
  logic [RunW-1:0]         run_cur, run_inc;
  logic [PositionBits-1:0] pos_cur;
  dmoms_pkg::hits_t        tally_cur;
  logic [MaxMotifBases-1:0] sym;
  logic                    is_base, check, sym_none, sym_one;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_xfer     = in_valid_i & ~in_stall_o;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motif_q     <= dmoms_pkg::MotifCodeRst;
      motif_len_q <= dmoms_pkg::MotifLengthRst;
      max_hits_q  <= dmoms_pkg::MaxHitsRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        dmoms_pkg::CFG_MOTIF_CODE:   motif_q     <= cfg_data_i;
        dmoms_pkg::CFG_MOTIF_LENGTH: motif_len_q <= cfg_data_i[dmoms_pkg::LenW-1:0];
        dmoms_pkg::CFG_MAX_HITS:     max_hits_q  <= cfg_data_i[dmoms_pkg::HitsW-1:0];
        default: ;
      endcase
    end
  end

  // effective motif length, clamped to 1..MaxMotifBases
  always_comb begin
    if (motif_len_q == '0) begin
      len_eff = dmoms_pkg::len_t'(1);
    end else if (motif_len_q > LenMax) begin
      len_eff = LenMax;
    end else begin
      len_eff = motif_len_q;
    end
  end

  // state seen by this character, cleared on a new read
  assign win_cur   = read_start_i ? '0 : win_q;
  assign run_cur   = read_start_i ? '0 : run_q;
  assign pos_cur   = read_start_i ? '0 : pos_q;
  assign tally_cur = read_start_i ? '0 : tally_q;

  assign code      = dmoms_pkg::base_code(base_char_i);
  assign is_base   = (code != dmoms_pkg::CodeNone);
  assign win_shift = (win_cur << 2) | WinW'(code[1:0]);
  assign run_inc   = (run_cur < RunMax) ? run_cur + RunW'(1) : run_cur;

  // per-base mismatch flags over the active motif length
  assign diff = win_shift ^ motif_q[WinW-1:0];
  always_comb begin
    for (int k = 0; k < MaxMotifBases; k++) begin
      sym[k] = (diff[2*k] | diff[2*k+1]) & (k < int'(len_eff));
    end
  end
  assign sym_none = (sym == '0);
  assign sym_one  = ((sym & (sym - MaxMotifBases'(1))) == '0);

  assign check = is_base && (dmoms_pkg::len_t'(run_inc) >= len_eff) && (tally_cur < max_hits_q);

  // next scan state and result
  always_comb begin
    win_d   = is_base ? win_shift : '0;
    run_d   = is_base ? run_inc : '0;
    pos_d   = (pos_cur < PosMax) ? pos_cur + PositionBits'(1) : pos_cur;
    found_d = check && sym_one;
    exact_d = check && sym_none;
    tally_d = found_d ? tally_cur + dmoms_pkg::hits_t'(1) : tally_cur;
    if (!found_d) begin
      start_d = '0;
    end else if (pos_cur == PosMax) begin
      start_d = PosMax;
    end else begin
      start_d = pos_cur - (PositionBits'(len_eff) - PositionBits'(1));
    end
  end

  // output register holds until taken
  always_comb begin
    if (in_xfer) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= '0;
      run_q       <= '0;
      pos_q       <= '0;
      tally_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_xfer) begin
        win_q   <= win_d;
        run_q   <= run_d;
        pos_q   <= pos_d;
        tally_q <= tally_d;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      start_q <= '0;
      exact_q <= 1'b0;
      hits_q  <= '0;
    end else if (in_xfer) begin
      found_q <= found_d;
      start_q <= start_d;
      exact_q <= exact_d;
      hits_q  <= tally_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_found_o    = found_q;
  assign hit_position_o = start_q;
  assign hit_exact_o    = exact_q;
  assign hits_so_far_o  = hits_q;

endmodule

@@ hdl/dmoms_check.sv @@
// Port-level checker for the motif scanner, with its bind to the top level.
module dmoms_check #(
  parameter int PositionBits = dmoms_pkg::PositionBitsDef
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic [dmoms_pkg::CharW-1:0] base_char_i,
  input logic                        read_start_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        hit_found_o,
  input logic [PositionBits-1:0]     hit_position_o,
  input logic                        hit_exact_o,
  input logic [dmoms_pkg::HitsW-1:0] hits_so_far_o
);

  logic in_xfer;
  assign in_xfer = in_valid_i && !in_stall_o;

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(hit_found_o)
      && $stable(hit_position_o) && $stable(hit_exact_o) && $stable(hits_so_far_o))
    else $error("stalled result changed");

  // no hit means empty position and exact flag
  a_no_hit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_found_o |-> hit_position_o == '0 && !hit_exact_o)
    else $error("fields set without a hit");

  // a reported hit is counted
  a_hit_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_found_o |-> hits_so_far_o != '0)
    else $error("hit with zero tally");

  // a new read restarts the tally
  a_read_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && read_start_i |=> out_valid_o && hits_so_far_o <= dmoms_pkg::hits_t'(1))
    else $error("tally not restarted on new read");

  // a character that is not a base never ends a hit
  a_nonbase_nohit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && dmoms_pkg::base_code(base_char_i) == dmoms_pkg::CodeNone
      |=> out_valid_o && !hit_found_o)
    else $error("hit on a non-base character");

endmodule

bind dna_motif_one_mismatch_scan dmoms_check #(.PositionBits(PositionBits)) u_dmoms_check (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .base_char_i    (base_char_i),
  .read_start_i   (read_start_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .hit_found_o    (hit_found_o),
  .hit_position_o (hit_position_o),
  .hit_exact_o    (hit_exact_o),
  .hits_so_far_o  (hits_so_far_o)
);
